// ----- design/mrm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrm_pkg
// Shared types, constants and arithmetic steps of the minimum rotation matrix
// pipeline.
// ----------------------------------------------------------------------------
package mrm_pkg;

    localparam int FRAC_BITS = 30;
    localparam int SQ_STEPS  = 32;
    localparam int DV_STEPS  = 31;
    localparam int NSTG      = 4 + SQ_STEPS + (DV_STEPS + 1) + 5
                               + SQ_STEPS + (DV_STEPS + 1) + 5;
    localparam int MW        = 36;

    localparam logic [30:0]          THR_RESET = 31'd107374;
    localparam logic signed [MW-1:0] ONE_M     = MW'(64'sd1 <<< FRAC_BITS);

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] r;
    } sq_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [30:0] num;
        logic [30:0] q;
        logic [31:0] d;
    } dv_t;

    typedef struct packed {
        logic [5:0][31:0] m;
        logic [5:0]       neg;
        logic             deg;
    } aside_t;

    typedef struct packed {
        logic [5:0] neg;
        logic       deg;
    } bside_t;

    typedef struct packed {
        logic [8:0][MW-1:0] sm;
        logic               sa_sel;
        logic [2:0][31:0]   nabs;
        logic [2:0]         nneg;
        logic [32:0]        ct;
        logic               deg;
    } cside_t;

    typedef struct packed {
        logic [8:0][MW-1:0] sm;
        logic               sa_sel;
        logic [2:0]         nneg;
        logic [32:0]        ct;
        logic               deg;
    } dside_t;

    // one step of the bitwise integer square root
    function automatic sq_t sq_step(input sq_t s, input int unsigned k);
        logic [63:0] b;
        sq_t         o;
        b = 64'd1 << (62 - 2 * k);
        o = s;
        if (s.x >= s.r + b) begin
            o.x = s.x - (s.r + b);
            o.r = (s.r >> 1) + b;
        end else begin
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    function automatic dv_t dv_init(input logic [61:0] n, input logic [31:0] d);
        dv_t o;
        o.rem = {1'b0, n[61:31]};
        o.num = n[30:0];
        o.q   = '0;
        o.d   = d;
        return o;
    endfunction

    // one restoring division step, one quotient bit
    function automatic dv_t dv_step(input dv_t s);
        logic [32:0] t;
        dv_t         o;
        t     = {s.rem, s.num[30]};
        o     = s;
        o.num = {s.num[29:0], 1'b0};
        if (t >= {1'b0, s.d}) begin
            o.rem = 32'(t - {1'b0, s.d});
            o.q   = {s.q[29:0], 1'b1};
        end else begin
            o.rem = t[31:0];
            o.q   = {s.q[29:0], 1'b0};
        end
        return o;
    endfunction

    // v / 2^sh rounded half away from zero
    function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                               input int unsigned sh);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    // left shift that brings the largest magnitude into [2^30, 2^31]
    function automatic logic [4:0] norm_shift(input logic [31:0] mx);
        logic [4:0] s;
        s = '0;
        for (int i = 0; i < 31; i++) begin
            if (mx[i]) s = 5'(30 - i);
        end
        return s;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [MW-1:0] v);
        logic [31:0] o;
        if (v > ONE_M) o = 32'(ONE_M);
        else if (v < -ONE_M) o = 32'(-ONE_M);
        else o = 32'(v);
        return o;
    endfunction

endpackage

// ----- design/minimum_rotation_matrix.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minimum_rotation_matrix
// Rotation matrix that turns one 3D direction into another, Q1.30 output.
// ----------------------------------------------------------------------------
// One item per cycle through 142 register stages, while no result waits on
// m_tready.
// The depth comes from two 32-step square root pipes (vector lengths, then
// the sine) and two 31-step divider pipes (unit vectors, then the unit axis).
// The whole pipe advances together; while a result waits on m_tready the
// pipe holds and s_tready is low. m_tuser is set and the matrix is identity
// when either input vector is all zero.
module minimum_rotation_matrix
    import mrm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [30:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // from_x, from_y, from_z, to_x, to_y, to_z
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22
    output logic [287:0] m_tdata,
    // degenerate
    output logic         m_tuser
);

    logic               adv;
    logic [NSTG-1:0]    vld_reg;
    logic [30:0]        thr_reg;

    logic [5:0][31:0]   mag_reg;
    logic [5:0]         neg_reg;
    logic [5:0][31:0]   msh_reg;
    logic [5:0]         neg2_reg;
    logic               deg2_reg;
    logic [5:0][31:0]   msh3_reg;
    logic [5:0]         neg3_reg;
    logic               deg3_reg;
    logic [5:0][63:0]   sqr_reg;

    sq_t                sqa_reg [SQ_STEPS+1][2];
    aside_t             aside_reg [SQ_STEPS+1];
    dv_t                dva_reg [DV_STEPS+1][6];
    bside_t             bside_reg [DV_STEPS+1];

    logic signed [63:0] xp_reg [3][3];
    logic               c1_deg_reg;
    logic signed [32:0] n_reg [3];
    logic signed [32:0] ct_reg;
    logic               c2_deg_reg;
    logic signed [63:0] nsq_reg [6];
    logic signed [32:0] n3_reg [3];
    logic signed [32:0] ct3_reg;
    logic               c3_deg_reg;
    logic [63:0]        st2_reg;
    logic signed [63:0] nsq4_reg [6];
    logic signed [32:0] n4_reg [3];
    logic signed [32:0] ct4_reg;
    logic               c4_deg_reg;

    sq_t                sqc_reg [SQ_STEPS+1];
    cside_t             cside_reg [SQ_STEPS+1];
    dv_t                dvc_reg [DV_STEPS+1][3];
    dside_t             dside_reg [DV_STEPS+1];

    logic signed [63:0] pp_reg [6];
    logic signed [63:0] skp_reg [3];
    logic signed [34:0] omc_reg;
    dside_t             e1_reg;
    logic signed [31:0] p_reg [6];
    logic signed [33:0] sk_reg [3];
    logic signed [34:0] omc2_reg;
    dside_t             e2_reg;
    logic signed [63:0] op_reg [6];
    logic signed [33:0] sk3_reg [3];
    dside_t             e3_reg;
    logic [8:0][MW-1:0] rm_reg;
    dside_t             e4_reg;
    logic [287:0]       out_data_reg;
    logic               out_deg_reg;

    logic [5:0][31:0]   mag_next;
    logic [5:0]         neg_next;
    logic [5:0][31:0]   msh_next;
    logic               deg_next;
    logic signed [31:0] ep_next [3];
    logic signed [31:0] eq_next [3];
    logic signed [31:0] nh_next [3];
    logic [8:0][MW-1:0] sm_next;
    logic               small_next;
    logic [8:0][MW-1:0] rm_next;
    logic [287:0]       out_data_next;

    assign adv      = !vld_reg[NSTG-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_deg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
        end
    end

    // magnitudes and block normalization shift
    always_comb begin
        logic [31:0] c;
        logic [31:0] mx;
        logic [4:0]  sh;
        logic        zero;
        for (int i = 0; i < 6; i++) begin
            c           = s_tdata[32*i +: 32];
            neg_next[i] = c[31];
            mag_next[i] = c[31] ? 32'(-c) : c;
        end
        deg_next = 1'b0;
        for (int v = 0; v < 2; v++) begin
            mx = mag_reg[3*v];
            if (mag_reg[3*v+1] > mx) mx = mag_reg[3*v+1];
            if (mag_reg[3*v+2] > mx) mx = mag_reg[3*v+2];
            sh   = norm_shift(mx);
            zero = (mx == '0);
            if (zero) deg_next = 1'b1;
            for (int j = 0; j < 3; j++) begin
                msh_next[3*v+j] = mag_reg[3*v+j] << sh;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag_reg  <= mag_next;
            neg_reg  <= neg_next;
            msh_reg  <= msh_next;
            neg2_reg <= neg_reg;
            deg2_reg <= deg_next;
            for (int i = 0; i < 6; i++) begin
                sqr_reg[i] <= 64'(msh_reg[i]) * 64'(msh_reg[i]);
            end
            msh3_reg <= msh_reg;
            neg3_reg <= neg2_reg;
            deg3_reg <= deg2_reg;
            for (int v = 0; v < 2; v++) begin
                sqa_reg[0][v].x <= sqr_reg[3*v] + sqr_reg[3*v+1] + sqr_reg[3*v+2];
                sqa_reg[0][v].r <= '0;
            end
            aside_reg[0] <= '{m: msh3_reg, neg: neg3_reg, deg: deg3_reg};
            for (int k = 1; k <= SQ_STEPS; k++) begin
                for (int v = 0; v < 2; v++) begin
                    sqa_reg[k][v] <= sq_step(sqa_reg[k-1][v], k - 1);
                end
                aside_reg[k] <= aside_reg[k-1];
            end
            for (int i = 0; i < 6; i++) begin
                dva_reg[0][i] <= dv_init(
                    {aside_reg[SQ_STEPS].m[i], 30'b0}
                        + 62'(sqa_reg[SQ_STEPS][i/3].r[31:1]),
                    sqa_reg[SQ_STEPS][i/3].r[31:0]);
            end
            bside_reg[0] <= '{neg: aside_reg[SQ_STEPS].neg, deg: aside_reg[SQ_STEPS].deg};
            for (int k = 1; k <= DV_STEPS; k++) begin
                for (int i = 0; i < 6; i++) begin
                    dva_reg[k][i] <= dv_step(dva_reg[k-1][i]);
                end
                bside_reg[k] <= bside_reg[k-1];
            end
        end
    end

    // unit vectors, cross and dot products
    always_comb begin
        logic signed [31:0] qa;
        logic signed [31:0] qb;
        for (int i = 0; i < 3; i++) begin
            qa = $signed({1'b0, dva_reg[DV_STEPS][i].q});
            qb = $signed({1'b0, dva_reg[DV_STEPS][i+3].q});
            ep_next[i] = bside_reg[DV_STEPS].neg[i]   ? -qa : qa;
            eq_next[i] = bside_reg[DV_STEPS].neg[i+3] ? -qb : qb;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    xp_reg[i][j] <= 64'(ep_next[i]) * 64'(eq_next[j]);
                end
            end
            c1_deg_reg <= bside_reg[DV_STEPS].deg;
            n_reg[0]   <= 33'(rnd(xp_reg[1][2] - xp_reg[2][1], FRAC_BITS));
            n_reg[1]   <= 33'(rnd(xp_reg[2][0] - xp_reg[0][2], FRAC_BITS));
            n_reg[2]   <= 33'(rnd(xp_reg[0][1] - xp_reg[1][0], FRAC_BITS));
            ct_reg     <= 33'(rnd(xp_reg[0][0] + xp_reg[1][1] + xp_reg[2][2], FRAC_BITS));
            c2_deg_reg <= c1_deg_reg;
            nsq_reg[0] <= 64'(n_reg[0]) * 64'(n_reg[0]);
            nsq_reg[1] <= 64'(n_reg[1]) * 64'(n_reg[1]);
            nsq_reg[2] <= 64'(n_reg[2]) * 64'(n_reg[2]);
            nsq_reg[3] <= 64'(n_reg[0]) * 64'(n_reg[1]);
            nsq_reg[4] <= 64'(n_reg[0]) * 64'(n_reg[2]);
            nsq_reg[5] <= 64'(n_reg[1]) * 64'(n_reg[2]);
            n3_reg     <= n_reg;
            ct3_reg    <= ct_reg;
            c3_deg_reg <= c2_deg_reg;
            st2_reg    <= 64'(nsq_reg[0] + nsq_reg[1] + nsq_reg[2]);
            nsq4_reg   <= nsq_reg;
            n4_reg     <= n3_reg;
            ct4_reg    <= ct3_reg;
            c4_deg_reg <= c3_deg_reg;
        end
    end

    // second-order small-angle matrix
    always_comb begin
        logic signed [MW-1:0] o01;
        logic signed [MW-1:0] o02;
        logic signed [MW-1:0] o12;
        logic signed [MW-1:0] nx;
        logic signed [MW-1:0] ny;
        logic signed [MW-1:0] nz;
        nx  = MW'(n4_reg[0]);
        ny  = MW'(n4_reg[1]);
        nz  = MW'(n4_reg[2]);
        o01 = MW'(rnd(nsq4_reg[3], FRAC_BITS + 1));
        o02 = MW'(rnd(nsq4_reg[4], FRAC_BITS + 1));
        o12 = MW'(rnd(nsq4_reg[5], FRAC_BITS + 1));
        for (int i = 0; i < 3; i++) begin
            sm_next[4*i] = ONE_M + MW'(rnd(nsq4_reg[i] - $signed(st2_reg), FRAC_BITS + 1));
        end
        sm_next[1] = o01 - nz;
        sm_next[2] = o02 + ny;
        sm_next[3] = o01 + nz;
        sm_next[5] = o12 - nx;
        sm_next[6] = o02 - ny;
        sm_next[7] = o12 + nx;
        small_next = (st2_reg == '0) || (st2_reg < {3'b0, thr_reg, 30'b0});
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sqc_reg[0].x <= st2_reg;
            sqc_reg[0].r <= '0;
            cside_reg[0].sm     <= sm_next;
            cside_reg[0].sa_sel <= small_next;
            cside_reg[0].ct     <= ct4_reg;
            cside_reg[0].deg    <= c4_deg_reg;
            for (int i = 0; i < 3; i++) begin
                cside_reg[0].nneg[i] <= n4_reg[i][32];
                cside_reg[0].nabs[i] <= n4_reg[i][32] ? 32'(-n4_reg[i]) : 32'(n4_reg[i]);
            end
            for (int k = 1; k <= SQ_STEPS; k++) begin
                sqc_reg[k]   <= sq_step(sqc_reg[k-1], k - 1);
                cside_reg[k] <= cside_reg[k-1];
            end
            for (int i = 0; i < 3; i++) begin
                dvc_reg[0][i] <= dv_init(
                    {cside_reg[SQ_STEPS].nabs[i], 30'b0}
                        + 62'(sqc_reg[SQ_STEPS].r[31:1]),
                    sqc_reg[SQ_STEPS].r[31:0]);
            end
            dside_reg[0] <= '{sm: cside_reg[SQ_STEPS].sm, sa_sel: cside_reg[SQ_STEPS].sa_sel,
                              nneg: cside_reg[SQ_STEPS].nneg, ct: cside_reg[SQ_STEPS].ct,
                              deg: cside_reg[SQ_STEPS].deg};
            for (int k = 1; k <= DV_STEPS; k++) begin
                for (int i = 0; i < 3; i++) begin
                    dvc_reg[k][i] <= dv_step(dvc_reg[k-1][i]);
                end
                dside_reg[k] <= dside_reg[k-1];
            end
        end
    end

    // rodrigues path on the unit axis
    always_comb begin
        logic signed [31:0] qa;
        for (int i = 0; i < 3; i++) begin
            qa = $signed({1'b0, dvc_reg[DV_STEPS][i].q});
            nh_next[i] = dside_reg[DV_STEPS].nneg[i] ? -qa : qa;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pp_reg[0] <= 64'(nh_next[0]) * 64'(nh_next[0]);
            pp_reg[1] <= 64'(nh_next[1]) * 64'(nh_next[1]);
            pp_reg[2] <= 64'(nh_next[2]) * 64'(nh_next[2]);
            pp_reg[3] <= 64'(nh_next[0]) * 64'(nh_next[1]);
            pp_reg[4] <= 64'(nh_next[0]) * 64'(nh_next[2]);
            pp_reg[5] <= 64'(nh_next[1]) * 64'(nh_next[2]);
            for (int i = 0; i < 3; i++) begin
                skp_reg[i] <= 64'(nh_next[i])
                              * $signed({32'b0, dvc_reg[DV_STEPS][0].d});
            end
            omc_reg  <= 35'(ONE_M) - 35'($signed(dside_reg[DV_STEPS].ct));
            e1_reg   <= dside_reg[DV_STEPS];
            for (int i = 0; i < 6; i++) begin
                p_reg[i] <= 32'(rnd(pp_reg[i], FRAC_BITS));
            end
            for (int i = 0; i < 3; i++) begin
                sk_reg[i] <= 34'(rnd(skp_reg[i], FRAC_BITS));
            end
            omc2_reg <= omc_reg;
            e2_reg   <= e1_reg;
            for (int i = 0; i < 6; i++) begin
                op_reg[i] <= 64'(p_reg[i]) * 64'(omc2_reg);
            end
            sk3_reg <= sk_reg;
            e3_reg  <= e2_reg;
            rm_reg  <= rm_next;
            e4_reg  <= e3_reg;
            out_data_reg <= out_data_next;
            out_deg_reg  <= e4_reg.deg;
        end
    end

    always_comb begin
        logic signed [MW-1:0] o01;
        logic signed [MW-1:0] o02;
        logic signed [MW-1:0] o12;
        logic signed [MW-1:0] ctm;
        logic signed [MW-1:0] sx;
        logic signed [MW-1:0] sy;
        logic signed [MW-1:0] sz;
        ctm = MW'($signed(e3_reg.ct));
        sx  = MW'(sk3_reg[0]);
        sy  = MW'(sk3_reg[1]);
        sz  = MW'(sk3_reg[2]);
        o01 = MW'(rnd(op_reg[3], FRAC_BITS));
        o02 = MW'(rnd(op_reg[4], FRAC_BITS));
        o12 = MW'(rnd(op_reg[5], FRAC_BITS));
        for (int i = 0; i < 3; i++) begin
            rm_next[4*i] = MW'(rnd(op_reg[i], FRAC_BITS)) + ctm;
        end
        rm_next[1] = o01 - sz;
        rm_next[2] = o02 + sy;
        rm_next[3] = o01 + sz;
        rm_next[5] = o12 - sx;
        rm_next[6] = o02 - sy;
        rm_next[7] = o12 + sx;
    end

    // path select and saturation
    always_comb begin
        logic signed [MW-1:0] v;
        for (int i = 0; i < 9; i++) begin
            if (e4_reg.deg) begin
                v = (i % 4 == 0) ? ONE_M : '0;
            end else if (e4_reg.sa_sel) begin
                v = $signed(e4_reg.sm[i]);
            end else begin
                v = $signed(rm_reg[i]);
            end
            out_data_next[32*i +: 32] = sat32(v);
        end
    end

`ifndef SYNTH
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_deg_identity: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> ($signed(m_tdata[31:0]) == 32'(ONE_M)
                                   && m_tdata[63:32] == '0
                                   && $signed(m_tdata[159:128]) == 32'(ONE_M)))
        else $error("degenerate item without identity matrix");

    a_sat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[63:32]) <= 32'(ONE_M)
                      && $signed(m_tdata[63:32]) >= -32'(ONE_M)))
        else $error("matrix entry outside unit range");

    a_zero_sine_small: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && vld_reg[71] && st2_reg == '0) |=> cside_reg[0].sa_sel)
        else $error("zero cross product not routed to small-angle form");
`endif

endmodule
